[design/tmr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmr_pkg
// Types and codes shared by the trap message ring with keyed take.
// ----------------------------------------------------------------------------
package tmr_pkg;

  localparam logic [1:0] ACT_POST     = 2'd0;
  localparam logic [1:0] ACT_TAKE_OLD = 2'd1;
  localparam logic [1:0] ACT_TAKE_KEY = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NONE    = 2'd2;
  localparam logic [1:0] ST_ZERO_ID = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] thread_id;
    logic [31:0] trap_address;
  } tmr_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] out_thread_id;
    logic [31:0] out_address;
  } tmr_out_t;

  typedef struct packed {
    logic [31:0] thread;
    logic [31:0] address;
  } tmr_slot_t;

  typedef enum logic [2:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_POST,
    FSM_SCAN,
    FSM_FINISH
  } tmr_state_t;

endpackage

[design/trap_message_ring_keyed_take.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trap_message_ring_keyed_take
// Ring of trap messages in one synchronous memory, with post, take-oldest
// and take-by-thread driven by a small read-modify-write sequencer.
// ----------------------------------------------------------------------------
// post: passes the POST and FINISH states to the result register, no-access item goes straight to FINISH
// take: scans up to DEPTH slots in the SCAN state, one slot of the ring checked per cycle
// throughput: one item at a time, next transfer the cycle after result is loaded
// reset: clearing pass over the slot memory, no transfer taken then
// pointers, live count and result valid are cleared by reset
// ----------------------------------------------------------------------------
module trap_message_ring_keyed_take #(
  parameter int DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tmr_pkg::tmr_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tmr_pkg::tmr_out_t out_data
);
  import tmr_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  tmr_slot_t mem [DEPTH];
  tmr_slot_t rd_data_r;

  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  tmr_slot_t       mem_wdata;

  tmr_state_t      state_r, state_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic [AW-1:0]   wp_r, wp_nxt;
  logic [AW-1:0]   rp_r, rp_nxt;
  logic [LW-1:0]   live_r, live_nxt;
  logic [AW-1:0]   iss_r, iss_nxt;
  logic [AW-1:0]   chk_r, chk_nxt;
  logic [AW-1:0]   chk_n_r, chk_n_nxt;
  logic [31:0]     key_r, key_nxt;
  logic [31:0]     addr_r, addr_nxt;
  logic            keyed_r, keyed_nxt;
  tmr_out_t        res_r, res_nxt;
  logic            out_valid_r, out_valid_nxt;
  tmr_out_t        out_data_r, out_data_nxt;

  logic            out_free;
  logic            hit;
  logic            last_slot;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign hit       = keyed_r ? (rd_data_r.thread == key_r) : (rd_data_r.thread != '0);
  assign last_slot = (chk_n_r == AW'(DEPTH - 1)) || (keyed_r && (ring_next(chk_r) == wp_r));

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    live_nxt      = live_r;
    iss_nxt       = iss_r;
    chk_nxt       = chk_r;
    chk_n_nxt     = chk_n_r;
    key_nxt       = key_r;
    addr_nxt      = addr_r;
    keyed_nxt     = keyed_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = clr_r;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = rp_r;
    in_stall      = (state_r != FSM_IDLE);

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      FSM_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = FSM_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      FSM_IDLE: begin
        if (in_valid) begin
          res_nxt   = '{status: ST_NONE, out_thread_id: '0, out_address: '0};
          key_nxt   = in_data.thread_id;
          addr_nxt  = in_data.trap_address;
          state_nxt = FSM_FINISH;
          case (in_data.action)
            ACT_POST: begin
              if (in_data.thread_id == '0) begin
                res_nxt.status = ST_ZERO_ID;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = wp_r;
                state_nxt = FSM_POST;
              end
            end
            ACT_TAKE_OLD, ACT_TAKE_KEY: begin
              if (live_r != '0) begin
                keyed_nxt = (in_data.action == ACT_TAKE_KEY) && (in_data.thread_id != '0);
                mem_re    = 1'b1;
                mem_raddr = rp_r;
                iss_nxt   = ring_next(rp_r);
                chk_nxt   = rp_r;
                chk_n_nxt = '0;
                state_nxt = FSM_SCAN;
              end
            end
            default: begin
              res_nxt.status = ST_NONE;
            end
          endcase
        end
      end
      FSM_POST: begin
        if ((live_r == LW'(DEPTH)) || (rd_data_r.thread != '0)) begin
          res_nxt.status = ST_FULL;
        end else begin
          mem_we         = 1'b1;
          mem_waddr      = wp_r;
          mem_wdata      = '{thread: key_r, address: addr_r};
          wp_nxt         = ring_next(wp_r);
          live_nxt       = live_r + 1'b1;
          res_nxt.status = ST_OK;
        end
        state_nxt = FSM_FINISH;
      end
      FSM_SCAN: begin
        mem_re    = 1'b1;
        mem_raddr = iss_r;
        iss_nxt   = ring_next(iss_r);
        chk_nxt   = iss_r;
        chk_n_nxt = chk_n_r + 1'b1;
        if (hit) begin
          mem_we    = 1'b1;
          mem_waddr = chk_r;
          mem_wdata = '0;
          live_nxt  = live_r - 1'b1;
          res_nxt   = '{status: ST_OK, out_thread_id: rd_data_r.thread,
                        out_address: rd_data_r.address};
          if (!keyed_r || (chk_r == rp_r)) begin
            rp_nxt = ring_next(chk_r);
          end
          state_nxt = FSM_FINISH;
        end else if (last_slot) begin
          res_nxt   = '{status: ST_NONE, out_thread_id: '0, out_address: '0};
          state_nxt = FSM_FINISH;
        end
      end
      FSM_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = FSM_IDLE;
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_CLEAR;
      clr_r       <= '0;
      wp_r        <= '0;
      rp_r        <= '0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
    end
    iss_r      <= iss_nxt;
    chk_r      <= chk_nxt;
    chk_n_r    <= chk_n_nxt;
    key_r      <= key_nxt;
    addr_r     <= addr_nxt;
    keyed_r    <= keyed_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= LW'(DEPTH))
    else $error("live count above ring depth");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == FSM_FINISH)
    else $error("result loaded outside finish");

  a_refused_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.status != ST_OK) |->
      (out_data_r.out_thread_id == '0) && (out_data_r.out_address == '0))
    else $error("refused result carries data");

  a_live_moves_on_access: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (live_r != $past(live_r)) |->
      ($past(state_r) == FSM_POST) || ($past(state_r) == FSM_SCAN))
    else $error("live count changed outside post or scan");

  a_no_transfer_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_CLEAR) |=> (state_r == FSM_CLEAR) || (state_r == FSM_IDLE))
    else $error("clearing pass left early");

endmodule

[dv/tmr_ring_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmr_ring_checker
// Watches both channels of the trap message ring. Every input transfer runs
// through a local copy of the ring (slots, pointers, live count) to produce
// the expected result. Every result transfer is compared field by field with
// the oldest expected result.
// ----------------------------------------------------------------------------
module tmr_ring_checker #(
  parameter int DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  tmr_pkg::tmr_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  tmr_pkg::tmr_out_t out_data,
  output int                mismatch_count,
  output int                results_owed
);
  import tmr_pkg::*;

  localparam int PW = $clog2(DEPTH);

  logic [31:0]   slot_id   [DEPTH];
  logic [31:0]   slot_addr [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   live;
  tmr_out_t      expected_results [$];

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) begin
      $display("%0t mismatch: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  function automatic logic [PW-1:0] ring_step(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic tmr_out_t no_message();
    tmr_out_t r;
    r = '0;
    r.status = ST_NONE;
    return r;
  endfunction

  function automatic tmr_out_t pull_slot(input logic [PW-1:0] idx);
    tmr_out_t r;
    r.status = ST_OK;
    r.out_thread_id = slot_id[idx];
    r.out_address = slot_addr[idx];
    slot_id[idx] = '0;
    live = live - 1'b1;
    return r;
  endfunction

  function automatic tmr_out_t take_oldest_msg();
    logic [PW-1:0] i;
    tmr_out_t r;
    if (live == 0) return no_message();
    i = rd_ptr;
    for (int n = 0; n < DEPTH; n++) begin
      if (slot_id[i] != '0) begin
        r = pull_slot(i);
        rd_ptr = ring_step(i);
        return r;
      end
      i = ring_step(i);
    end
    return no_message();
  endfunction

  function automatic tmr_out_t take_thread_msg(input logic [31:0] key);
    logic [PW-1:0] i;
    tmr_out_t r;
    if (live == 0) return no_message();
    i = rd_ptr;
    for (int n = 0; n < DEPTH; n++) begin
      if (slot_id[i] == key) begin
        r = pull_slot(i);
        if (i == rd_ptr) rd_ptr = ring_step(rd_ptr);
        return r;
      end
      i = ring_step(i);
      if (i == wr_ptr) break;
    end
    return no_message();
  endfunction

  function automatic tmr_out_t predict_ring_item(input tmr_in_t item);
    tmr_out_t r;
    r = '0;
    case (item.action)
      ACT_POST: begin
        if (item.thread_id == '0) begin
          r.status = ST_ZERO_ID;
        end else if (live >= DEPTH || slot_id[wr_ptr] != '0) begin
          r.status = ST_FULL;
        end else begin
          slot_id[wr_ptr] = item.thread_id;
          slot_addr[wr_ptr] = item.trap_address;
          wr_ptr = ring_step(wr_ptr);
          live = live + 1'b1;
          r.status = ST_OK;
        end
      end
      ACT_TAKE_OLD: r = take_oldest_msg();
      ACT_TAKE_KEY: begin
        if (item.thread_id == '0) r = take_oldest_msg();
        else r = take_thread_msg(item.thread_id);
      end
      default: r = no_message();
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    tmr_out_t want;
    if (!rst_n) begin
      for (int k = 0; k < DEPTH; k++) begin
        slot_id[k] = '0;
        slot_addr[k] = '0;
      end
      wr_ptr = '0;
      rd_ptr = '0;
      live = '0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result status %0d thread %h address %h",
                                    out_data.status, out_data.out_thread_id,
                                    out_data.out_address));
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", out_data.status, want.status));
          if (out_data.out_thread_id !== want.out_thread_id)
            report_mismatch($sformatf("thread %h, want %h", out_data.out_thread_id,
                                      want.out_thread_id));
          if (out_data.out_address !== want.out_address)
            report_mismatch($sformatf("address %h, want %h", out_data.out_address,
                                      want.out_address));
        end
      end
      if (in_valid && !in_stall) expected_results.push_back(predict_ring_item(in_data));
    end
    results_owed = expected_results.size();
  end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the trap message ring with a directed opening (empty takes, zero
// ids, unused action, holes, keyed hits and misses) and then random phases
// biased toward filling, draining or keyed removal, with random idling on
// both channels. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import tmr_pkg::*;

  localparam int RING_DEPTH = 64;
  localparam int RANDOM_ITEMS = 1530;
  localparam int IDLE_LIMIT = 2000;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  tmr_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  tmr_out_t out_data;
  logic     calm;
  int       fail_count;
  int       results_owed;
  int       idle_cycles;

  trap_message_ring_keyed_take #(
    .DEPTH(RING_DEPTH)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  tmr_ring_checker #(
    .DEPTH(RING_DEPTH)
  ) checker_i (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .mismatch_count(fail_count),
    .results_owed(results_owed)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // result side: random stall before each transfer
  initial begin : result_sink
    int hold;
    out_stall = 1'b0;
    forever begin
      hold = calm ? 0 : $urandom_range(0, 8);
      repeat (hold) @(negedge clk) out_stall <= 1'b1;
      @(negedge clk) out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  function automatic tmr_in_t trap_item(input logic [1:0] act, input logic [31:0] tid,
                                        input logic [31:0] addr);
    tmr_in_t item;
    item.action = act;
    item.thread_id = tid;
    item.trap_address = addr;
    return item;
  endfunction

  function automatic logic [31:0] pick_thread();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 14) return $urandom;
    if (r < 18) return 32'hFFFF_FFFF;
    return $urandom_range(1, 24);
  endfunction

  function automatic tmr_in_t random_item(input int post_pct);
    int r;
    tmr_in_t item;
    r = $urandom_range(0, 99);
    item.trap_address = $urandom;
    item.thread_id = pick_thread();
    if (r < post_pct) begin
      item.action = ACT_POST;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 5) item.action = ACT_UNUSED;
      else if (r < 45) item.action = ACT_TAKE_OLD;
      else item.action = ACT_TAKE_KEY;
    end
    return item;
  endfunction

  task automatic send_item(input tmr_in_t item);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    repeat (gap) @(negedge clk) in_valid <= 1'b0;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  task automatic hold_until_drained();
    @(negedge clk) in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    int sent;
    int len;
    int post_pct;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    calm = 1'b0;
    sent = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // empty ring, refused post, unused action
    send_item(trap_item(ACT_POST, 32'h0, 32'hFFFF_FFFF));
    send_item(trap_item(ACT_TAKE_OLD, 32'h0, 32'h0));
    send_item(trap_item(ACT_TAKE_KEY, 32'h5, 32'h0));
    send_item(trap_item(ACT_TAKE_KEY, 32'h0, 32'h0));
    send_item(trap_item(ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    // extremes of id and address
    send_item(trap_item(ACT_POST, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(trap_item(ACT_POST, 32'h1, 32'h0));
    send_item(trap_item(ACT_POST, 32'h7, 32'h1234_5678));
    send_item(trap_item(ACT_POST, 32'h9, 32'hA5A5_A5A5));
    send_item(trap_item(ACT_POST, 32'h8000_0000, 32'h5A5A_5A5A));
    // keyed take away from the read pointer leaves a hole
    send_item(trap_item(ACT_TAKE_KEY, 32'h7, 32'h0));
    // keyed take at the read pointer
    send_item(trap_item(ACT_TAKE_KEY, 32'hFFFF_FFFF, 32'h0));
    send_item(trap_item(ACT_TAKE_KEY, 32'h2A, 32'h0));
    send_item(trap_item(ACT_UNUSED, 32'h9, 32'h0));
    send_item(trap_item(ACT_TAKE_OLD, 32'h0, 32'h0));
    // zero key acts as take oldest and skips the hole
    send_item(trap_item(ACT_TAKE_KEY, 32'h0, 32'h0));
    send_item(trap_item(ACT_POST, 32'h7, 32'h0000_0001));
    send_item(trap_item(ACT_TAKE_KEY, 32'h7, 32'h0));
    send_item(trap_item(ACT_TAKE_OLD, 32'h0, 32'h0));
    send_item(trap_item(ACT_TAKE_OLD, 32'h0, 32'h0));
    send_item(trap_item(ACT_TAKE_KEY, 32'h8000_0000, 32'h0));
    hold_until_drained();

    // phases: fill, drain, mixed, keyed heavy
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0: post_pct = 90;
        1: post_pct = 10;
        2: post_pct = 50;
        default: post_pct = 35;
      endcase
      len = $urandom_range(20, 120);
      if (len > RANDOM_ITEMS - sent) len = RANDOM_ITEMS - sent;
      calm = ($urandom_range(0, 3) == 0);
      repeat (len) send_item(random_item(post_pct));
      sent += len;
      if ($urandom_range(0, 2) == 0) hold_until_drained();
    end

    hold_until_drained();
    repeat (RING_DEPTH + 10) @(negedge clk);
    if (fail_count == 0 && results_owed == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial idle_cycles = 0;

endmodule
